// ----- sv/local_peak_top_k_distinct_assert.svh -----
// assertion macros for the local peak top-k block
`ifndef LOCAL_PEAK_TOP_K_DISTINCT_ASSERT_SVH
`define LOCAL_PEAK_TOP_K_DISTINCT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define LPK_ASSERT_IMP(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("lpk assertion failed");

// next-cycle implication
`define LPK_ASSERT_NXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("lpk assertion failed");

`endif

// ----- sv/lpk_pkg.sv -----
// shared types and constants for the local peak top-k block
`timescale 1ns / 1ps
package lpk_pkg;

	localparam int TOP_MAX_DEF     = 16;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int PORT_BITS       = 16;
	localparam int KEEP_BITS       = 5;
	localparam int QUEUE_DEPTH     = 4;

	// what the front hands to the back with each queued transaction
	typedef struct packed {
		logic has_peak;
		logic report;
	} cmd_t;

	localparam int CMD_BITS = $bits(cmd_t);

endpackage

// ----- sv/local_peak_top_k_distinct.sv -----
// A sample is classified combinationally in the front, queued, and inserted when the back pops it.
// Throughput: one sample per cycle while no report runs; the four-entry queue absorbs
// a few samples while the back reports. A report is planned as it is popped, slides an
// ascending list of n values to the end, then gives one result a cycle while out_stall is low.
// Reset: arst_n clears run state, fill count, queue and output valid; keep_count to 1.
`timescale 1ns / 1ps
module local_peak_top_k_distinct #(
	parameter int TOP_MAX     = lpk_pkg::TOP_MAX_DEF,
	parameter int SAMPLE_BITS = lpk_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [lpk_pkg::KEEP_BITS-1:0] cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lpk_pkg::PORT_BITS-1:0] sample_value,
	input  logic                          final_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lpk_pkg::PORT_BITS-1:0] peak_value,
	output logic                          none_found,
	output logic                          last_of_report
);

	localparam int QW = lpk_pkg::CMD_BITS + SAMPLE_BITS;

	logic [lpk_pkg::KEEP_BITS-1:0] keep_count_q;
	logic                          q_push;
	logic                          q_full;
	logic                          q_empty;
	logic                          q_pop;
	lpk_pkg::cmd_t                 f_cmd;
	logic [SAMPLE_BITS-1:0]        f_value;
	lpk_pkg::cmd_t                 b_cmd;
	logic [SAMPLE_BITS-1:0]        b_value;
	logic [QW-1:0]                 q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= lpk_pkg::KEEP_BITS'(1);
		end else if (cfg_wr_en) begin
			keep_count_q <= cfg_wr_data;
		end
	end

	lpk_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_value (sample_value),
		.final_sample (final_sample),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (f_cmd),
		.q_value      (f_value)
	);

	lpk_queue #(
		.DW    (QW),
		.DEPTH (lpk_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    ({f_cmd, f_value}),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign b_cmd   = q_dout[QW-1:SAMPLE_BITS];
	assign b_value = q_dout[SAMPLE_BITS-1:0];

	lpk_back #(
		.TOP_MAX     (TOP_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.q_cmd          (b_cmd),
		.q_value        (b_value),
		.keep_count     (keep_count_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.peak_value     (peak_value),
		.none_found     (none_found),
		.last_of_report (last_of_report)
	);

`include "local_peak_top_k_distinct_assert.svh"

	// an empty report is a single transaction carrying a zero value
	`LPK_ASSERT_IMP(a_none_is_last, out_valid && none_found, last_of_report)
	`LPK_ASSERT_IMP(a_none_zero, out_valid && none_found, peak_value == '0)
	// front never writes into a full queue
	`LPK_ASSERT_IMP(a_no_overflow, q_push, !q_full)
	// the back takes nothing from an empty queue
	`LPK_ASSERT_IMP(a_no_underflow, q_pop, !q_empty)

endmodule

// ----- sv/lpk_front.sv -----
// front part: run tracking and peak classification
`timescale 1ns / 1ps
module lpk_front #(
	parameter int SAMPLE_BITS = lpk_pkg::SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [lpk_pkg::PORT_BITS-1:0] sample_value,
	input  logic                         final_sample,
	input  logic                         q_full,
	output logic                         q_push,
	output lpk_pkg::cmd_t                q_cmd,
	output logic [SAMPLE_BITS-1:0]       q_value
);

	logic [SAMPLE_BITS-1:0] prev_q;
	logic [SAMPLE_BITS-1:0] earlier_q;
	logic [1:0]             seen_q;
	logic [SAMPLE_BITS-1:0] cur;
	logic                   accept;
	logic                   left_ok;
	logic                   prev_peak;
	logic                   cur_peak;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign cur      = SAMPLE_BITS'(sample_value);

	// first sample of a run only needs to beat its right neighbor
	assign left_ok   = (seen_q == 2'd1) || (prev_q > earlier_q);
	assign prev_peak = (seen_q != 2'd0) && left_ok && (prev_q > cur);
	assign cur_peak  = final_sample && ((seen_q == 2'd0) || (cur > prev_q));

	assign q_cmd.has_peak = prev_peak || cur_peak;
	assign q_cmd.report   = final_sample;
	assign q_value        = prev_peak ? prev_q : cur;
	assign q_push         = accept && (prev_peak || cur_peak || final_sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			earlier_q <= '0;
			seen_q    <= '0;
		end else if (accept) begin
			if (final_sample) begin
				prev_q    <= '0;
				earlier_q <= '0;
				seen_q    <= '0;
			end else begin
				prev_q    <= cur;
				earlier_q <= prev_q;
				if (seen_q != 2'd2) begin
					seen_q <= seen_q + 2'd1;
				end
			end
		end
	end

endmodule

// ----- sv/lpk_queue.sv -----
// short register queue between front and back
`timescale 1ns / 1ps
module lpk_queue #(
	parameter int DW    = 18,
	parameter int DEPTH = lpk_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] din,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] dout,
	output logic          empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- sv/lpk_back.sv -----
// back part: sorted distinct top list, insertion and report sequencing
`timescale 1ns / 1ps
module lpk_back #(
	parameter int TOP_MAX     = lpk_pkg::TOP_MAX_DEF,
	parameter int SAMPLE_BITS = lpk_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	output logic                           q_pop,
	input  lpk_pkg::cmd_t                  q_cmd,
	input  logic [SAMPLE_BITS-1:0]         q_value,
	input  logic [lpk_pkg::KEEP_BITS-1:0]  keep_count,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lpk_pkg::PORT_BITS-1:0]  peak_value,
	output logic                           none_found,
	output logic                           last_of_report
);

	localparam int KW = $clog2(TOP_MAX + 1);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_ALIGN = 2'd1;
	localparam logic [1:0] PH_EMIT  = 2'd2;

	logic [SAMPLE_BITS-1:0] top_q   [TOP_MAX];
	logic [SAMPLE_BITS-1:0] top_ins [TOP_MAX];
	logic [TOP_MAX-1:0]     above;
	logic [TOP_MAX:0]       above_ext;
	logic [TOP_MAX-1:0]     equal;
	logic                   dup;
	logic                   drop;
	logic                   do_ins;
	logic [KW-1:0]          kk;
	logic [KW-1:0]          fill_q;
	logic [KW-1:0]          fill_c;
	logic [KW-1:0]          n_next;
	logic [1:0]             phase_q;
	logic                   asc_q;
	logic                   none_q;
	logic [KW-1:0]          remain_q;
	logic [KW-1:0]          align_q;
	logic                   out_valid_q;
	logic                   emit_load;
	logic                   shift_l;
	logic                   shift_r;
	logic                   plan_none;
	logic                   plan_asc;
	logic [SAMPLE_BITS-1:0] peak_q;
	logic                   none_out_q;
	logic                   last_q;

	// k clamped to 1..TOP_MAX
	always_comb begin
		priority if (keep_count == '0) begin
			kk = KW'(1);
		end else if (32'(keep_count) > 32'(TOP_MAX)) begin
			kk = KW'(TOP_MAX);
		end else begin
			kk = KW'(keep_count);
		end
	end

	assign fill_c = (fill_q > kk) ? kk : fill_q;

	// parallel compare against every kept entry, list is descending
	always_comb begin
		for (int j = 0; j < TOP_MAX; j++) begin
			above[j] = (KW'(j) < fill_c) && (top_q[j] > q_value);
			equal[j] = (KW'(j) < fill_c) && (top_q[j] == q_value);
		end
		drop = 1'b0;
		for (int j = 0; j < TOP_MAX; j++) begin
			if ((KW'(j) == kk - KW'(1)) && above[j]) begin
				drop = 1'b1;
			end
		end
		above_ext = {above, 1'b1};
		top_ins[0] = above[0] ? top_q[0] : q_value;
		for (int j = 1; j < TOP_MAX; j++) begin
			if (above[j]) begin
				top_ins[j] = top_q[j];
			end else if (above_ext[j]) begin
				top_ins[j] = q_value;
			end else begin
				top_ins[j] = top_q[j - 1];
			end
		end
	end

	assign dup    = |equal;
	assign q_pop  = !q_empty && (phase_q == PH_IDLE);
	assign do_ins = q_pop && q_cmd.has_peak && !dup && !drop;
	assign n_next = do_ins ? ((fill_c < kk) ? fill_c + KW'(1) : kk) : fill_c;

	assign plan_none = (n_next == '0);
	assign plan_asc  = (n_next < kk);

	assign emit_load = (phase_q == PH_EMIT) && (!out_valid_q || !out_stall);
	assign shift_l   = emit_load && !asc_q && !none_q;
	// ascending reports first slide the list to the far end, then read from there
	assign shift_r   = (phase_q == PH_ALIGN) || (emit_load && asc_q && !none_q);

	always_ff @(posedge clk) begin
		if (do_ins) begin
			top_q <= top_ins;
		end else if (shift_l) begin
			for (int j = 0; j < TOP_MAX - 1; j++) begin
				top_q[j] <= top_q[j + 1];
			end
		end else if (shift_r) begin
			for (int j = 1; j < TOP_MAX; j++) begin
				top_q[j] <= top_q[j - 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			fill_q   <= '0;
			asc_q    <= 1'b0;
			none_q   <= 1'b0;
			remain_q <= '0;
			align_q  <= '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (q_pop) begin
						if (q_cmd.report) begin
							fill_q   <= '0;
							none_q   <= plan_none;
							asc_q    <= plan_asc;
							remain_q <= plan_asc ? n_next : kk;
							align_q  <= KW'(TOP_MAX) - n_next;
							if (!plan_none && plan_asc && (n_next != KW'(TOP_MAX))) begin
								phase_q <= PH_ALIGN;
							end else begin
								phase_q <= PH_EMIT;
							end
						end else begin
							fill_q <= n_next;
						end
					end
				end
				PH_ALIGN: begin
					align_q <= align_q - KW'(1);
					if (align_q == KW'(1)) begin
						phase_q <= PH_EMIT;
					end
				end
				PH_EMIT: begin
					if (emit_load) begin
						remain_q <= remain_q - KW'(1);
						if (none_q || (remain_q == KW'(1))) begin
							phase_q <= PH_IDLE;
						end
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			peak_q     <= none_q ? '0 : (asc_q ? top_q[TOP_MAX - 1] : top_q[0]);
			none_out_q <= none_q;
			last_q     <= none_q || (remain_q == KW'(1));
		end
	end

	assign out_valid      = out_valid_q;
	assign peak_value     = lpk_pkg::PORT_BITS'(peak_q);
	assign none_found     = none_out_q;
	assign last_of_report = last_q;

endmodule
